FILE: design/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared widths, register indexes and reset values for the Sobel gradient
// stream core.
// ----------------------------------------------------------------------------
package sgs_pkg;

   localparam int SGS_PIXEL_W       = 8;
   localparam int SGS_GRAD_W        = 11;
   localparam int SGS_WIDTH_W       = 12;
   localparam int SGS_HEIGHT_W      = 13;
   localparam int SGS_CSR_DATA_W    = 13;
   localparam int SGS_CSR_INDEX_W   = 1;

   localparam int SGS_MAX_WIDTH     = 2048;
   localparam int SGS_MAX_HEIGHT    = 4096;
   localparam int SGS_MIN_DIM       = 3;
   localparam int SGS_BORDER        = 2;

   localparam logic [SGS_WIDTH_W-1:0]  SGS_WIDTH_RESET  = 12'd1280;
   localparam logic [SGS_HEIGHT_W-1:0] SGS_HEIGHT_RESET = 13'd720;

   typedef enum logic [SGS_CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } sgs_csr_index_type;

endpackage

FILE: design/sgs_stream_if.sv
// ----------------------------------------------------------------------------
// sgs_pixel_if / sgs_grad_if
// Valid/ready channels for pixel beats in and gradient beats out.
// ----------------------------------------------------------------------------
interface sgs_pixel_if import sgs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SGS_PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface sgs_grad_if import sgs_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [SGS_GRAD_W-1:0] grad_x;
   logic signed [SGS_GRAD_W-1:0] grad_y;
   logic                         frame_last;

   modport source (output valid, output grad_x, output grad_y, output frame_last,
                   input ready);
   modport sink   (input valid, input grad_x, input grad_y, input frame_last,
                   output ready);
endinterface

FILE: design/sgs_line_buffer.sv
// ----------------------------------------------------------------------------
// sgs_line_buffer
// One line of pixel storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgs_line_buffer import sgs_pkg::*; #(
   parameter int DEPTH  = SGS_MAX_WIDTH,
   parameter int DATA_W = SGS_PIXEL_W,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sobel_gradient_stream_core.sv
// ----------------------------------------------------------------------------
// sobel_gradient_stream_core
// 3x3 Sobel x/y gradient over a raster pixel stream, one result per pixel.
//
//   channel     dir  beat contents                    handshake
//   req_stream  in   pixel[7:0]                       valid/ready
//   rsp_stream  out  grad_x[10:0] grad_y[10:0] last   valid/ready
//   csr_*       in   index[0] data[12:0]              write enable only
//
// One pixel per clock sustained while rsp_stream keeps up; each pixel passes
// the read stage (line store read), then the output register (gradient sum).
// Reset clears counters, window and valids; line stores are not cleared.
// A stalled result holds in the output register while one more pixel waits
// in the read stage; then req_stream.ready drops.
// ----------------------------------------------------------------------------
module sobel_gradient_stream_core import sgs_pkg::*; #(
   parameter int MAX_WIDTH  = SGS_MAX_WIDTH,
   parameter int MAX_HEIGHT = SGS_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   sgs_pixel_if.sink                  req_stream,
   sgs_grad_if.source                 rsp_stream,
   input  logic                       csr_wr_en,
   input  logic [SGS_CSR_INDEX_W-1:0] csr_index,
   input  logic [SGS_CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [SGS_WIDTH_W-1:0]  width_ff;
   logic [SGS_HEIGHT_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;

   logic                    s1_valid_ff;
   logic [SGS_PIXEL_W-1:0]  s1_pixel_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic                    s1_inner_ff;
   logic                    s1_last_ff;

   logic [SGS_PIXEL_W-1:0]  win_ff [6];

   logic                         out_valid_ff;
   logic signed [SGS_GRAD_W-1:0] out_gx_ff;
   logic signed [SGS_GRAD_W-1:0] out_gy_ff;
   logic                         out_last_ff;

   logic [31:0]             w_eff;
   logic [31:0]             h_eff;
   logic [COL_W-1:0]        w_last;
   logic [ROW_W-1:0]        h_last;
   logic                    end_col;
   logic                    end_row;
   logic                    accept;
   logic                    out_free;
   logic                    s1_adv;
   logic [SGS_PIXEL_W-1:0]  top_rd;
   logic [SGS_PIXEL_W-1:0]  mid_rd;
   logic signed [SGS_GRAD_W-1:0] gx_in;
   logic signed [SGS_GRAD_W-1:0] gy_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SGS_WIDTH_RESET;
         height_ff <= SGS_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data[SGS_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data[SGS_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = 32'(width_ff);
      if (w_eff < 32'(SGS_MIN_DIM)) begin
         w_eff = 32'(SGS_MIN_DIM);
      end else if (w_eff > 32'(MAX_WIDTH)) begin
         w_eff = 32'(MAX_WIDTH);
      end
      h_eff = 32'(height_ff);
      if (h_eff < 32'(SGS_MIN_DIM)) begin
         h_eff = 32'(SGS_MIN_DIM);
      end else if (h_eff > 32'(MAX_HEIGHT)) begin
         h_eff = 32'(MAX_HEIGHT);
      end
      w_last = COL_W'(w_eff - 32'd1);
      h_last = ROW_W'(h_eff - 32'd1);
   end

   assign end_col  = col_ff >= w_last;
   assign end_row  = row_ff >= h_last;

   assign out_free = !out_valid_ff || rsp_stream.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_stream.ready = !s1_valid_ff || out_free;
   assign accept   = req_stream.valid && req_stream.ready;

   // position counters advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (end_col) begin
            col_ff <= '0;
            row_ff <= end_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_stream.pixel;
         s1_col_ff   <= col_ff;
         s1_inner_ff <= (row_ff >= ROW_W'(SGS_BORDER)) && (col_ff >= COL_W'(SGS_BORDER));
         s1_last_ff  <= end_col && end_row;
      end
   end

   sgs_line_buffer #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (SGS_PIXEL_W)
   ) u_older (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (top_rd)
   );

   sgs_line_buffer #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (SGS_PIXEL_W)
   ) u_newer (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // gradient sums
   always_comb begin
      logic signed [SGS_GRAD_W-1:0] t, m, b, l0, l1, l2, c0, c2;
      t  = $signed({3'b000, top_rd});
      m  = $signed({3'b000, mid_rd});
      b  = $signed({3'b000, s1_pixel_ff});
      l0 = $signed({3'b000, win_ff[0]});
      l1 = $signed({3'b000, win_ff[1]});
      l2 = $signed({3'b000, win_ff[2]});
      c0 = $signed({3'b000, win_ff[3]});
      c2 = $signed({3'b000, win_ff[5]});
      if (s1_inner_ff) begin
         gx_in = (t - l0) + ((m - l1) <<< 1) + (b - l2);
         gy_in = (l2 - l0) + ((c2 - c0) <<< 1) + (b - t);
      end else begin
         gx_in = '0;
         gy_in = '0;
      end
   end

   // window: shift one column per advanced beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_rd;
         win_ff[4] <= mid_rd;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_gx_ff   <= gx_in;
         out_gy_ff   <= gy_in;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_stream.valid      = out_valid_ff;
   assign rsp_stream.grad_x     = out_gx_ff;
   assign rsp_stream.grad_y     = out_gy_ff;
   assign rsp_stream.frame_last = out_last_ff;

endmodule

FILE: design/sgs_checker.sv
// ----------------------------------------------------------------------------
// sgs_checker
// Port-level checks on beat ordering and occupancy of the gradient core.
// ----------------------------------------------------------------------------
module sgs_checker import sgs_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [SGS_GRAD_W-1:0] rsp_grad_x,
   input logic signed [SGS_GRAD_W-1:0] rsp_grad_y,
   input logic                         rsp_frame_last
);

   logic [2:0] pending_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         pending_ff <= pending_ff + 3'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_ff <= pending_ff - 3'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grad_x)
         && $stable(rsp_grad_y) && $stable(rsp_frame_last))
      else $error("result beat changed while stalled");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more than two pixels in flight");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result beat without a pending pixel");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd0 |-> req_ready)
      else $error("input stalled while pipeline empty");

endmodule

bind sobel_gradient_stream_core sgs_checker u_sgs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_stream.valid),
   .req_ready      (req_stream.ready),
   .rsp_valid      (rsp_stream.valid),
   .rsp_ready      (rsp_stream.ready),
   .rsp_grad_x     (rsp_stream.grad_x),
   .rsp_grad_y     (rsp_stream.grad_y),
   .rsp_frame_last (rsp_stream.frame_last)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sobel_gradient_stream_core. Raster frames of pixel
// beats go in through a bursty driver. Each accepted beat is run through a
// local Sobel predictor that keeps its own line stores, window and counters.
// A monitor with its own stall pattern checks every gradient beat against the
// oldest prediction. Frame sizes cover the clamped low register values,
// registers lowered mid-frame, and many small random frames.
// ----------------------------------------------------------------------------
module tb_top import sgs_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam int unsigned RANDOM_TARGET = 1600;
   localparam int unsigned HOLDOFF_LEN   = 300;

   typedef struct packed {
      logic signed [SGS_GRAD_W-1:0] grad_x;
      logic signed [SGS_GRAD_W-1:0] grad_y;
      logic                         frame_last;
   } grad_beat_type;

   typedef enum int {FILL_NOISE, FILL_EXTREMES, FILL_RAMP} fill_style_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [SGS_CSR_INDEX_W-1:0] csr_index;
   logic [SGS_CSR_DATA_W-1:0]  csr_wr_data;

   sgs_pixel_if req_if ();
   sgs_grad_if  rsp_if ();

   sobel_gradient_stream_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_stream  (req_if),
      .rsp_stream  (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   logic [SGS_PIXEL_W-1:0]  pixel_queue [$];
   grad_beat_type           grad_expected [$];

   logic [SGS_PIXEL_W-1:0]  older_line [SGS_MAX_WIDTH];
   logic [SGS_PIXEL_W-1:0]  newer_line [SGS_MAX_WIDTH];
   logic [SGS_PIXEL_W-1:0]  win_col [6];
   int unsigned             col_pos;
   int unsigned             row_pos;
   logic [SGS_WIDTH_W-1:0]  cfg_width;
   logic [SGS_HEIGHT_W-1:0] cfg_height;

   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned pixels_sent;
   int unsigned results_seen;
   int unsigned csr_writes;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned holdoff_left;
   int unsigned holdoff_mark;
   int unsigned pattern_age;
   logic [15:0] ready_pattern;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < SGS_MIN_DIM) return SGS_MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned frame_pixels();
      return clamp_dim(cfg_width, SGS_MAX_WIDTH) * clamp_dim(cfg_height, SGS_MAX_HEIGHT);
   endfunction

   function automatic grad_beat_type sobel_predict(logic [SGS_PIXEL_W-1:0] px);
      grad_beat_type beat;
      int unsigned   w_lim, h_lim;
      int            top, mid, bot, l0, l1, l2, c0, c2, gx, gy;
      logic          line_end, last_row;
      w_lim = clamp_dim(cfg_width, SGS_MAX_WIDTH);
      h_lim = clamp_dim(cfg_height, SGS_MAX_HEIGHT);
      bot = int'(px);
      top = int'(older_line[col_pos]);
      mid = int'(newer_line[col_pos]);
      l0 = int'(win_col[0]);
      l1 = int'(win_col[1]);
      l2 = int'(win_col[2]);
      c0 = int'(win_col[3]);
      c2 = int'(win_col[5]);
      gx = 0;
      gy = 0;
      if (row_pos >= SGS_BORDER && col_pos >= SGS_BORDER) begin
         gx = (top - l0) + 2 * (mid - l1) + (bot - l2);
         gy = (l2 - l0) + 2 * (c2 - c0) + (bot - top);
      end
      line_end = (col_pos >= w_lim - 1);
      last_row = (row_pos >= h_lim - 1);
      beat.grad_x = gx[SGS_GRAD_W-1:0];
      beat.grad_y = gy[SGS_GRAD_W-1:0];
      beat.frame_last = line_end && last_row;
      older_line[col_pos] = mid[SGS_PIXEL_W-1:0];
      newer_line[col_pos] = px;
      win_col[0] = win_col[3];
      win_col[1] = win_col[4];
      win_col[2] = win_col[5];
      win_col[3] = top[SGS_PIXEL_W-1:0];
      win_col[4] = mid[SGS_PIXEL_W-1:0];
      win_col[5] = px;
      if (line_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return beat;
   endfunction

   task automatic wait_idle();
      while (pixel_queue.size() != 0 || req_if.valid || grad_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(sgs_csr_index_type idx, logic [SGS_CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH)
         cfg_width = data[SGS_WIDTH_W-1:0];
      else
         cfg_height = data[SGS_HEIGHT_W-1:0];
      csr_writes++;
   endtask

   task automatic queue_pixels(fill_style_type style, int unsigned count);
      logic [SGS_PIXEL_W-1:0] px;
      for (int unsigned i = 0; i < count; i++) begin
         case (style)
            FILL_EXTREMES: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_RAMP:     px = 8'(i * 7 + $urandom_range(0, 15));
            default:       px = 8'($urandom_range(0, 255));
         endcase
         pixel_queue.push_back(px);
      end
   endtask

   task automatic queue_row(logic [SGS_PIXEL_W-1:0] a, logic [SGS_PIXEL_W-1:0] b,
                            logic [SGS_PIXEL_W-1:0] c);
      pixel_queue.push_back(a);
      pixel_queue.push_back(b);
      pixel_queue.push_back(c);
   endtask

   // sender: bursts of random length with random gaps, valid held until taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            grad_expected.push_back(sobel_predict(req_if.pixel));
            pixel_queue.delete(0);
            pixels_sent++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (gap_left != 0 || pixel_queue.size() == 0) begin
               req_if.valid <= 1'b0;
               if (gap_left != 0) gap_left--;
            end else begin
               req_if.valid <= 1'b1;
               req_if.pixel <= pixel_queue[0];
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: check each gradient beat, then pick the next ready value
   always @(posedge clock) begin
      grad_beat_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (grad_expected.size() == 0) begin
               $error("gradient beat with no pixel pending");
               fail_count++;
            end else begin
               want = grad_expected.pop_front();
               if (rsp_if.grad_x !== want.grad_x) begin
                  $error("grad_x: expected %0d, got %0d", want.grad_x, rsp_if.grad_x);
                  fail_count++;
               end
               if (rsp_if.grad_y !== want.grad_y) begin
                  $error("grad_y: expected %0d, got %0d", want.grad_y, rsp_if.grad_y);
                  fail_count++;
               end
               if (rsp_if.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0b, got %0b",
                         want.frame_last, rsp_if.frame_last);
                  fail_count++;
               end
            end
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
         end else if (results_seen >= holdoff_mark && pixel_queue.size() > 4) begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_mark = results_seen + $urandom_range(3000, 9000);
            rsp_if.ready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               case ($urandom_range(0, 3))
                  0:       ready_pattern = 16'hFFFF;
                  1:       ready_pattern = 16'($urandom | $urandom);
                  2:       ready_pattern = 16'($urandom) | 16'h0001;
                  default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
               endcase
            end
            rsp_if.ready <= ready_pattern[pattern_age % 16];
            pattern_age = (pattern_age + 1) % 64;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int unsigned random_items;
      int unsigned frames;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.pixel   = '0;
      rsp_if.ready   = 1'b0;
      cfg_width      = SGS_WIDTH_RESET;
      cfg_height     = SGS_HEIGHT_RESET;
      col_pos        = 0;
      row_pos        = 0;
      foreach (older_line[i]) older_line[i] = '0;
      foreach (newer_line[i]) newer_line[i] = '0;
      foreach (win_col[i]) win_col[i] = '0;
      cycle_count    = 0;
      fail_count     = 0;
      pixels_sent    = 0;
      results_seen   = 0;
      csr_writes     = 0;
      burst_left     = 0;
      gap_left       = 0;
      holdoff_left   = 0;
      holdoff_mark   = 600;
      pattern_age    = 0;
      ready_pattern  = 16'hFFFF;
      random_items   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // low register values clamp to a 3x3 frame; full-scale x then y gradient
      csr_write(CSR_IMAGE_WIDTH, 13'd0);
      csr_write(CSR_IMAGE_HEIGHT, 13'd1);
      repeat (3) queue_row(8'd0, 8'd128, 8'd255);
      queue_row(8'd255, 8'd255, 8'd255);
      queue_row(8'd128, 8'd128, 8'd128);
      queue_row(8'd0, 8'd0, 8'd0);

      // lower width, then height, while the counters sit past the new limit
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 13'd6);
      csr_write(CSR_IMAGE_HEIGHT, 13'd7);
      queue_pixels(FILL_NOISE, 16);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 13'd3);
      queue_pixels(FILL_NOISE, 10);
      wait_idle();
      csr_write(CSR_IMAGE_HEIGHT, 13'd4);
      queue_pixels(FILL_NOISE, 15);

      // small random frames
      while (random_items < RANDOM_TARGET) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       csr_write(CSR_IMAGE_WIDTH, 13'($urandom_range(0, 2)));
            1:       csr_write(CSR_IMAGE_WIDTH, 13'h1000 | 13'($urandom_range(3, 16)));
            default: csr_write(CSR_IMAGE_WIDTH, 13'($urandom_range(3, 24)));
         endcase
         if ($urandom_range(0, 9) == 0)
            csr_write(CSR_IMAGE_HEIGHT, 13'($urandom_range(0, 2)));
         else
            csr_write(CSR_IMAGE_HEIGHT, 13'($urandom_range(3, 8)));
         frames = $urandom_range(1, 2);
         repeat (frames) queue_pixels(fill_style_type'($urandom_range(0, 2)), frame_pixels());
         random_items += frames * frame_pixels();
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (grad_expected.size() != 0) begin
         $error("%0d gradient beats never arrived", grad_expected.size());
         fail_count++;
      end
      $display("summary: %0d pixel beats sent, %0d gradient beats checked, %0d register writes",
               pixels_sent, results_seen, csr_writes);
      $display("summary: %0d mismatches in %0d cycles", fail_count, cycle_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sobel_gradient_stream_core.f
design/sgs_pkg.sv
design/sgs_stream_if.sv
design/sgs_line_buffer.sv
design/sobel_gradient_stream_core.sv
design/sgs_checker.sv
test/tb_top.sv
